FILE: sv/udp_dmx_pkg.sv
// Shared types and constants for the UDP port demultiplexer.
package udp_dmx_pkg;

   localparam int DefaultPortSlots = 64;
   localparam int DefaultQueueDepth = 16;

   localparam logic [7:0] UdpProtocol = 8'd17;
   localparam logic [15:0] UdpHeaderBytes = 16'd8;

   typedef enum logic [1:0] {
      KIND_BIND = 2'd0,
      KIND_DELIVER = 2'd1,
      KIND_RECEIVE = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BIND_REFUSED = 3'd1,
      ST_NOT_BOUND = 3'd2,
      ST_EMPTY = 3'd3,
      ST_DROPPED = 3'd4
   } status_type;

   // Classified command handed from the front part to the back part.
   typedef struct packed {
      kind_type    kind;
      logic        hit;
      logic [15:0] port;
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [15:0] src_port;
      logic [15:0] udp_length;
      logic [15:0] max_length;
   } cmd_type;

endpackage

FILE: sv/udp_port_demux_queue.sv
// Top level of the UDP port demultiplexer with per-port descriptor queues.
// Each command (bind, deliver, receive) is taken when start is high and busy is low.
// The front part searches the port table one slot per cycle; after the scan the back
// part reads the slot's queue pointers and takes the command in the next cycle. Busy
// therefore stays high from the accepting edge until the back part has taken the
// command, so a new command is accepted only after the previous one has been taken.
// The result is on the rsp ports for exactly one cycle, marked by rsp_strobe, and is
// registered when the back part takes the command; a successful receive first reads
// the queue memory, so its result comes in the cycle after. The next command may
// enter the front part while the back part finishes the previous one. Results cannot
// be stalled. Kind value 3 is consumed without any result.
module udp_port_demux_queue import udp_dmx_pkg::*; #(
   parameter int PORT_SLOTS = DefaultPortSlots,
   parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_port,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_source_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_udp_length,
   input  logic [15:0] req_max_length,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_from_address,
   output logic [15:0] rsp_from_port,
   output logic [15:0] rsp_byte_count
);

   localparam int SlotBits = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;

   cmd_type             start_cmd, cmd_data;
   logic                cmd_valid, cmd_take;
   logic [SlotBits-1:0] cmd_slot;

   // Gather the request fields into one command.
   always_comb begin
      start_cmd = '0;
      start_cmd.kind = kind_type'(req_kind);
      start_cmd.port = req_port;
      start_cmd.protocol = req_protocol;
      start_cmd.source_address = req_source_address;
      start_cmd.src_port = req_source_port;
      start_cmd.udp_length = req_udp_length;
      start_cmd.max_length = req_max_length;
   end

   udp_dmx_front #(.PORT_SLOTS(PORT_SLOTS)) u_front (
      .clock(clock), .reset(reset),
      .start_valid(start), .start_cmd(start_cmd), .front_busy(busy),
      .cmd_valid(cmd_valid), .cmd_data(cmd_data), .cmd_slot(cmd_slot),
      .cmd_take(cmd_take)
   );

   udp_dmx_back #(.PORT_SLOTS(PORT_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_data(cmd_data), .cmd_slot(cmd_slot),
      .cmd_take(cmd_take),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_from_address(rsp_from_address), .rsp_from_port(rsp_from_port),
      .rsp_byte_count(rsp_byte_count)
   );

endmodule

FILE: sv/udp_dmx_front.sv
// Front part: port table search, bind handling and command classification.
module udp_dmx_front import udp_dmx_pkg::*; #(
   parameter int PORT_SLOTS = DefaultPortSlots,
   localparam int SlotBits = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start_valid,
   input  cmd_type             start_cmd,
   output logic                front_busy,
   output logic                cmd_valid,
   output cmd_type             cmd_data,
   output logic [SlotBits-1:0] cmd_slot,
   input  logic                cmd_take
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_SCAN = 3'b010,
      F_HOLD = 3'b100
   } fstate_type;

   fstate_type          state_ff, state_in;
   logic [PORT_SLOTS-1:0] valid_ff, valid_in;
   logic [15:0]         port_ff [PORT_SLOTS];
   cmd_type             cmd_ff, cmd_in;
   logic [SlotBits:0]   idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic [SlotBits-1:0] hslot_ff, hslot_in;
   logic                free_ff, free_in;
   logic [SlotBits-1:0] fslot_ff, fslot_in;
   logic                bind_we;
   logic [SlotBits-1:0] cur;
   logic [SlotBits-1:0] raddr;
   logic                rvalid_ff;
   logic [15:0]         rport_ff;

   assign cur = idx_ff[SlotBits-1:0];
   assign raddr = idx_in[SlotBits-1:0];
   assign front_busy = (state_ff != F_IDLE);
   assign cmd_valid = (state_ff == F_HOLD);
   assign cmd_data = cmd_ff;
   assign cmd_slot = hslot_ff;

   // Scan one slot a cycle; at the end, for a bind, claim a free slot if the port is not
   // yet bound, then hand the command on. The table entry for slot cur was read at the previous edge.
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      hslot_in = hslot_ff;
      free_in = free_ff;
      fslot_in = fslot_ff;
      bind_we = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (start_valid) begin
               cmd_in = start_cmd;
               idx_in = '0;
               hit_in = 1'b0;
               free_in = 1'b0;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (rvalid_ff && rport_ff == cmd_ff.port && !hit_ff) begin
               hit_in = 1'b1;
               hslot_in = cur;
            end
            if (!rvalid_ff && !free_ff) begin
               free_in = 1'b1;
               fslot_in = cur;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (SlotBits+1)'(PORT_SLOTS - 1)) begin
               if (cmd_ff.kind == KIND_BIND) begin
                  bind_we = !hit_in && free_in;
                  if (bind_we) begin
                     valid_in[fslot_in] = 1'b1;
                     hslot_in = fslot_in;
                  end
                  cmd_in.hit = bind_we;
               end else begin
                  cmd_in.hit = hit_in;
               end
               state_in = F_HOLD;
            end
         end
         F_HOLD: begin
            if (cmd_take) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      hslot_ff <= hslot_in;
      free_ff <= free_in;
      fslot_ff <= fslot_in;
      if (bind_we) port_ff[fslot_in] <= cmd_ff.port;
      // Registered read of the slot examined in the next cycle.
      rport_ff <= port_ff[raddr];
      rvalid_ff <= valid_ff[raddr];
   end

endmodule

FILE: sv/udp_dmx_back.sv
// Back part: per-slot descriptor queues in one memory and result generation.
module udp_dmx_back import udp_dmx_pkg::*; #(
   parameter int PORT_SLOTS = DefaultPortSlots,
   parameter int QUEUE_DEPTH = DefaultQueueDepth,
   localparam int SlotBits = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1,
   localparam int PosBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int FillBits = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd_data,
   input  logic [SlotBits-1:0] cmd_slot,
   output logic                cmd_take,
   output logic                rsp_strobe,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_from_address,
   output logic [15:0]         rsp_from_port,
   output logic [15:0]         rsp_byte_count
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_FETCH = 3'b010,
      B_READ = 3'b100
   } bstate_type;

   bstate_type           state_ff, state_in;
   logic [PosBits-1:0]   head_ff [PORT_SLOTS];
   logic [FillBits-1:0]  fill_ff [PORT_SLOTS];
   logic [PosBits-1:0]   head_rd_ff;
   logic [FillBits-1:0]  fill_rd_ff;
   logic [63:0]          mem [PORT_SLOTS * QUEUE_DEPTH];
   logic [63:0]          rd_ff;
   logic [15:0]          maxl_ff;
   logic                 strobe_ff;
   logic [2:0]           status_ff;
   logic [31:0]          addr_ff;
   logic [15:0]          fport_ff, count_ff;
   logic [PosBits-1:0]   head, tail, nhead;
   logic [FillBits-1:0]  fill;
   logic [PosBits:0]     tsum;
   logic                 enq, deq, rd_go;
   logic [SlotBits+PosBits-1:0] waddr, raddr;

   // Queue pointers of the slot, registered in the cycle before the command is taken.
   assign head = head_rd_ff;
   assign fill = fill_rd_ff;
   assign tsum = {1'b0, head} + (PosBits+1)'(fill);
   assign tail = (tsum >= (PosBits+1)'(QUEUE_DEPTH)) ?
                 PosBits'(tsum - (PosBits+1)'(QUEUE_DEPTH)) : tsum[PosBits-1:0];
   assign nhead = (head == PosBits'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
   assign waddr = (SlotBits+PosBits)'(cmd_slot * QUEUE_DEPTH + tail);
   assign raddr = (SlotBits+PosBits)'(cmd_slot * QUEUE_DEPTH + head);

   assign cmd_take = cmd_valid && (state_ff == B_FETCH);
   assign enq = cmd_take && cmd_data.kind == KIND_DELIVER && cmd_data.hit
                && cmd_data.protocol == UdpProtocol
                && cmd_data.udp_length >= UdpHeaderBytes
                && fill < FillBits'(QUEUE_DEPTH);
   assign rd_go = cmd_take && cmd_data.kind == KIND_RECEIVE && cmd_data.hit
                  && fill != '0;
   assign deq = rd_go;

   // Sequencing: fetch the slot pointers, take the command, then, for a successful receive, read the queue.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (cmd_valid) state_in = B_FETCH;
         B_FETCH: state_in = rd_go ? B_READ : B_IDLE;
         B_READ: state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Queue pointer updates, memory access and result registers.
   // A slot's pointers are only used after a bind has cleared them.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= (cmd_take && !rd_go && cmd_data.kind != KIND_UNUSED)
                      || state_ff == B_READ;
         if (cmd_take && cmd_data.kind == KIND_BIND && cmd_data.hit) begin
            head_ff[cmd_slot] <= '0;
            fill_ff[cmd_slot] <= '0;
         end
         if (enq) fill_ff[cmd_slot] <= fill + 1'b1;
         if (deq) begin
            head_ff[cmd_slot] <= nhead;
            fill_ff[cmd_slot] <= fill - 1'b1;
         end
      end
      head_rd_ff <= head_ff[cmd_slot];
      fill_rd_ff <= fill_ff[cmd_slot];
      if (enq) mem[waddr] <= {cmd_data.source_address, cmd_data.src_port,
                              cmd_data.udp_length - UdpHeaderBytes};
      rd_ff <= mem[raddr];
      if (cmd_take) maxl_ff <= cmd_data.max_length;
      // Results for everything but a successful receive are known at once.
      if (state_ff == B_READ) begin
         status_ff <= ST_OK;
         addr_ff <= rd_ff[63:32];
         fport_ff <= rd_ff[31:16];
         count_ff <= (maxl_ff < rd_ff[15:0]) ? maxl_ff : rd_ff[15:0];
      end else begin
         addr_ff <= '0;
         fport_ff <= '0;
         count_ff <= '0;
         unique case (cmd_data.kind)
            KIND_BIND: status_ff <= cmd_data.hit ? ST_OK : ST_BIND_REFUSED;
            KIND_DELIVER: status_ff <= enq ? ST_OK : ST_DROPPED;
            KIND_RECEIVE: status_ff <= !cmd_data.hit ? ST_NOT_BOUND : ST_EMPTY;
            default: status_ff <= ST_OK;
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_from_address = addr_ff;
   assign rsp_from_port = fport_ff;
   assign rsp_byte_count = count_ff;

endmodule
